FILE: design/pscv_pkg.sv
// Shared constants and types for the pump speed unit converter.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
package pscv_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FULL_STEPS   = 3'd0;
  localparam logic [2:0] REG_MICROSTEP    = 3'd1;
  localparam logic [2:0] REG_GEAR_NUM     = 3'd2;
  localparam logic [2:0] REG_GEAR_DEN     = 3'd3;
  localparam logic [2:0] REG_DISPLACEMENT = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // Conversion modes
  localparam logic [1:0] MODE_RPM_TO_FREQ  = 2'd0;
  localparam logic [1:0] MODE_FREQ_TO_RPM  = 2'd1;
  localparam logic [1:0] MODE_FLOW_TO_RPM  = 2'd2;

  // Field widths
  localparam int unsigned FullStepsW = 16;
  localparam int unsigned MicroW     = 9;
  localparam int unsigned GearW      = 16;
  localparam int unsigned DispW      = 31;
  localparam int unsigned SprW       = 41;  // full steps * microsteps * numerator
  localparam int unsigned FlowMulW   = 42;  // |flow| * 1000
  localparam int unsigned QuotW      = 73;  // |speed| * spr, widest dividend

  // Reset values
  localparam logic [FullStepsW-1:0] RST_FULL_STEPS   = 16'd200;
  localparam logic [MicroW-1:0]     RST_MICROSTEP    = 9'd16;
  localparam logic [GearW-1:0]      RST_GEAR_NUM     = 16'd1;
  localparam logic [GearW-1:0]      RST_GEAR_DEN     = 16'd1;
  localparam logic [DispW-1:0]      RST_DISPLACEMENT = 31'd1000;

  // Sideband carried through the steps-per-rev divider
  typedef struct packed {
    logic [1:0]          mode;
    logic                dir_fwd;
    logic [31:0]         speed_mag;
    logic [63:0]         freq;
    logic                flow_neg;
    logic [FlowMulW-1:0] flow_mul;
    logic [DispW-1:0]    disp;
    logic                gd_zero;
  } front_side_t;

  // Sideband carried through the main divider
  typedef struct packed {
    logic [1:0] mode;
    logic       dir_fwd;
    logic       flow_neg;
    logic       disp_zero;
    logic       spr_zero;
  } back_side_t;

endpackage

FILE: design/pscv_in_if.sv
// Input channel of the pump speed converter: valid/ready plus item fields.
// No dependencies.
`timescale 1ns / 1ps
interface pscv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] speed_milli_rpm;
  logic [63:0]        step_freq_millihertz;
  logic               direction_forward;
  logic signed [31:0] flow_ul_per_min;

  modport source (output valid, mode, speed_milli_rpm, step_freq_millihertz,
                  direction_forward, flow_ul_per_min, input ready);
  modport sink (input valid, mode, speed_milli_rpm, step_freq_millihertz,
                direction_forward, flow_ul_per_min, output ready);
endinterface

FILE: design/pscv_out_if.sv
// Result channel of the pump speed converter: valid/ready plus result fields.
// No dependencies.
`timescale 1ns / 1ps
interface pscv_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        freq_out_millihertz;
  logic signed [31:0] rpm_out_milli;
  logic               saturated;

  modport source (output valid, freq_out_millihertz, rpm_out_milli, saturated,
                  input ready);
  modport sink (input valid, freq_out_millihertz, rpm_out_milli, saturated,
                output ready);
endinterface

FILE: design/pscv_div_cell.sv
// One restoring division step: shift in one dividend bit, subtract if it fits.
// Standalone; instantiated by pscv_div_chain.
`timescale 1ns / 1ps
module pscv_div_cell #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic          vld_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q;
  logic [SW-1:0] side_q;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    fits  = (trial >= {1'b0, den_i});
    rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
    num_d = {num_i[NW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

FILE: design/pscv_div_chain.sv
// Row of NW division cells; the quotient is taken from the last cell's registers.
// Depends on pscv_div_cell.
`timescale 1ns / 1ps
module pscv_div_chain #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          vld  [NW+1];
  logic [DW-1:0] rem  [NW+1];
  logic [NW-1:0] num  [NW+1];
  logic [DW-1:0] den  [NW+1];
  logic [SW-1:0] side [NW+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = '0;
  assign num[0]  = num_i;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    pscv_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld[g]),
      .rem_i  (rem[g]),
      .num_i  (num[g]),
      .den_i  (den[g]),
      .side_i (side[g]),
      .vld_o  (vld[g+1]),
      .rem_o  (rem[g+1]),
      .num_o  (num[g+1]),
      .den_o  (den[g+1]),
      .side_o (side[g+1])
    );
  end

  assign vld_o  = vld[NW];
  assign quot_o = num[NW];
  assign side_o = side[NW];

endmodule

FILE: design/pump_speed_unit_converter_core.sv
// Stepper pump speed converter, top level.
// Depends on pscv_pkg, pscv_in_if, pscv_out_if and pscv_div_chain.
`timescale 1ns / 1ps
// Usage:
//   in_i carries one conversion request per transfer (mode, speed, step
//   frequency, direction, flow); out_o returns exactly one result per request,
//   in order. The cfg_* port writes one register per cycle while cfg_we_i is
//   high; each request takes a snapshot of the registers when it is accepted.
//   An accepted request passes through 119 register stages before it appears
//   on out_o: the transfer edge loads the first of them (two multiply
//   stages, a 41-cell steps-per-rev divider, two product stages, a
//   73-cell main divider and the output register).
//   Throughput is one request per cycle while the output is not stalled; every
//   cell of both divider rows resolves one quotient bit and hands its partial remainder on each cycle.
//   Reset clears all valid bits and loads the register defaults
//   (200 steps, 16 microsteps, ratio 1/1, 1000 uL/rev).
//   When the receiver stalls with a result pending, the whole pipeline holds;
//   in_i.ready follows out_o.ready then, so a new request is still taken in
//   any cycle the output register drains or is empty.
module pump_speed_unit_converter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pscv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pscv_pkg::CfgDataW-1:0]  cfg_data_i,
  pscv_in_if.sink                        in_i,
  pscv_out_if.source                     out_o
);

  localparam int unsigned SprW  = pscv_pkg::SprW;
  localparam int unsigned QW    = pscv_pkg::QuotW;
  localparam int unsigned FSW   = $bits(pscv_pkg::front_side_t);
  localparam int unsigned BSW   = $bits(pscv_pkg::back_side_t);

  // Configuration registers
  logic [pscv_pkg::FullStepsW-1:0] fs_q;
  logic [pscv_pkg::MicroW-1:0]     ms_q;
  logic [pscv_pkg::GearW-1:0]      gn_q;
  logic [pscv_pkg::GearW-1:0]      gd_q;
  logic [pscv_pkg::DispW-1:0]      disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= pscv_pkg::RST_FULL_STEPS;
      ms_q   <= pscv_pkg::RST_MICROSTEP;
      gn_q   <= pscv_pkg::RST_GEAR_NUM;
      gd_q   <= pscv_pkg::RST_GEAR_DEN;
      disp_q <= pscv_pkg::RST_DISPLACEMENT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pscv_pkg::REG_FULL_STEPS:   fs_q   <= cfg_data_i[pscv_pkg::FullStepsW-1:0];
        pscv_pkg::REG_MICROSTEP:    ms_q   <= cfg_data_i[pscv_pkg::MicroW-1:0];
        pscv_pkg::REG_GEAR_NUM:     gn_q   <= cfg_data_i[pscv_pkg::GearW-1:0];
        pscv_pkg::REG_GEAR_DEN:     gd_q   <= cfg_data_i[pscv_pkg::GearW-1:0];
        pscv_pkg::REG_DISPLACEMENT: disp_q <= cfg_data_i[pscv_pkg::DispW-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the output register can take
  // a new result.
  logic out_vld_q;
  logic adv;
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: magnitudes, flow * 1000, full steps * microsteps
  logic [31:0]                   spd_raw, spd_mag, flw_raw, flw_mag;
  pscv_pkg::front_side_t         side0;
  logic                          s1_vld_q;
  logic [24:0]                   p1_q;
  logic [pscv_pkg::GearW-1:0]    gn1_q, gd1_q;
  pscv_pkg::front_side_t         side1_q;

  always_comb begin
    spd_raw = in_i.speed_milli_rpm;
    flw_raw = in_i.flow_ul_per_min;
    spd_mag = spd_raw[31] ? (~spd_raw + 32'd1) : spd_raw;
    flw_mag = flw_raw[31] ? (~flw_raw + 32'd1) : flw_raw;
    side0.mode      = in_i.mode;
    side0.dir_fwd   = in_i.direction_forward;
    side0.speed_mag = spd_mag;
    side0.freq      = in_i.step_freq_millihertz;
    side0.flow_neg  = flw_raw[31];
    side0.flow_mul  = {10'd0, flw_mag} * 42'd1000;
    side0.disp      = disp_q;
    side0.gd_zero   = (gd_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q    <= {9'd0, fs_q} * {16'd0, ms_q};
      gn1_q   <= gn_q;
      gd1_q   <= gd_q;
      side1_q <= side0;
    end
  end

  // Stage 2: times the gear numerator
  logic                        s2_vld_q;
  logic [SprW-1:0]             p2_q;
  logic [pscv_pkg::GearW-1:0]  gd2_q;
  pscv_pkg::front_side_t       side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q    <= {16'd0, p1_q} * {25'd0, gn1_q};
      gd2_q   <= gd1_q;
      side2_q <= side1_q;
    end
  end

  // Steps per revolution divider
  logic                  c1_vld;
  logic [SprW-1:0]       spr;
  logic [FSW-1:0]        c1_side_raw;
  pscv_pkg::front_side_t c1_side;

  pscv_div_chain #(.NW(SprW), .DW(pscv_pkg::GearW), .SW(FSW)) u_spr_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s2_vld_q),
    .num_i  (p2_q),
    .den_i  (gd2_q),
    .side_i (side2_q),
    .vld_o  (c1_vld),
    .quot_o (spr),
    .side_o (c1_side_raw)
  );
  assign c1_side = c1_side_raw;

  // Stage M1: partial products of |speed| * spr, frequency * 60
  logic                  m1_vld_q;
  logic [63:0]           pa_q;
  logic [40:0]           pb_q;
  logic [69:0]           f60_q;
  logic [SprW-1:0]       spr_q;
  logic [pscv_pkg::FlowMulW-1:0] fm1_q;
  logic [pscv_pkg::DispW-1:0]    disp1_q;
  pscv_pkg::back_side_t  bside1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= c1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q  <= {32'd0, c1_side.speed_mag} * {32'd0, spr[31:0]};
      pb_q  <= {9'd0, c1_side.speed_mag} * {32'd0, spr[40:32]};
      f60_q <= {c1_side.freq, 6'd0} - {4'd0, c1_side.freq, 2'd0};
      spr_q <= spr;
      fm1_q <= c1_side.flow_mul;
      disp1_q <= c1_side.disp;
      bside1_q.mode      <= c1_side.mode;
      bside1_q.dir_fwd   <= c1_side.dir_fwd;
      bside1_q.flow_neg  <= c1_side.flow_neg;
      bside1_q.disp_zero <= (c1_side.disp == '0);
      bside1_q.spr_zero  <= c1_side.gd_zero || (spr == '0);
    end
  end

  // Stage M2: sum partials, pick dividend and divisor for the mode
  logic [QW-1:0]         prod;
  logic [QW-1:0]         num_sel;
  logic [SprW-1:0]       den_sel;
  logic                  m2_vld_q;
  logic [QW-1:0]         num2_q;
  logic [SprW-1:0]       den2_q;
  pscv_pkg::back_side_t  bside2_q;

  always_comb begin
    prod = {9'd0, pa_q} + {pb_q, 32'd0};
    unique case (bside1_q.mode)
      pscv_pkg::MODE_RPM_TO_FREQ: begin
        num_sel = prod;
        den_sel = 41'd60;
      end
      pscv_pkg::MODE_FREQ_TO_RPM: begin
        num_sel = {3'd0, f60_q};
        den_sel = spr_q;
      end
      pscv_pkg::MODE_FLOW_TO_RPM: begin
        num_sel = {31'd0, fm1_q};
        den_sel = {10'd0, disp1_q};
      end
      default: begin
        num_sel = '0;
        den_sel = 41'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num2_q   <= num_sel;
      den2_q   <= den_sel;
      bside2_q <= bside1_q;
    end
  end

  // Main divider
  logic                 c2_vld;
  logic [QW-1:0]        quot;
  logic [BSW-1:0]       c2_side_raw;
  pscv_pkg::back_side_t c2_side;

  pscv_div_chain #(.NW(QW), .DW(SprW), .SW(BSW)) u_main_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (m2_vld_q),
    .num_i  (num2_q),
    .den_i  (den2_q),
    .side_i (bside2_q),
    .vld_o  (c2_vld),
    .quot_o (quot),
    .side_o (c2_side_raw)
  );
  assign c2_side = c2_side_raw;

  // Result formatting: clamp, sign, zero the unused field
  logic [63:0] freq_d;
  logic [31:0] rpm_d;
  logic [31:0] mag1;
  logic        sat_d;

  always_comb begin
    freq_d = '0;
    rpm_d  = '0;
    sat_d  = 1'b0;
    mag1   = '0;
    unique case (c2_side.mode)
      pscv_pkg::MODE_RPM_TO_FREQ: begin
        if (!c2_side.spr_zero) begin
          if (quot[QW-1:64] != '0) begin
            freq_d = '1;
            sat_d  = 1'b1;
          end else begin
            freq_d = quot[63:0];
          end
        end
      end
      pscv_pkg::MODE_FREQ_TO_RPM: begin
        if (!c2_side.spr_zero) begin
          if (quot > 73'h7FFF_FFFF) begin
            mag1  = 32'h7FFF_FFFF;
            sat_d = 1'b1;
          end else begin
            mag1 = quot[31:0];
          end
          rpm_d = c2_side.dir_fwd ? mag1 : (~mag1 + 32'd1);
        end
      end
      pscv_pkg::MODE_FLOW_TO_RPM: begin
        if (!c2_side.disp_zero) begin
          if (c2_side.flow_neg) begin
            if (quot > 73'h8000_0000) begin
              rpm_d = 32'h8000_0000;
              sat_d = 1'b1;
            end else begin
              rpm_d = ~quot[31:0] + 32'd1;
            end
          end else begin
            if (quot > 73'h7FFF_FFFF) begin
              rpm_d = 32'h7FFF_FFFF;
              sat_d = 1'b1;
            end else begin
              rpm_d = quot[31:0];
            end
          end
        end
      end
      default: ; // undefined mode: all-zero result
    endcase
  end

  // Output register
  logic [63:0] out_freq_q;
  logic [31:0] out_rpm_q;
  logic        out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_freq_q <= freq_d;
      out_rpm_q  <= rpm_d;
      out_sat_q  <= sat_d;
    end
  end

  assign out_o.valid               = out_vld_q;
  assign out_o.freq_out_millihertz = out_freq_q;
  assign out_o.rpm_out_milli       = out_rpm_q;
  assign out_o.saturated           = out_sat_q;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for pump_speed_unit_converter_core: directed and
// random conversions across register settings, checked against an in-bench
// model. Depends on pscv_pkg, pscv_in_if, pscv_out_if and the design files.
`timescale 1ns / 1ps
module tb_top;

  // Mode 3 carries no conversion; the block must return an all-zero result.
  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int         PIPE_LAT    = 119;
  localparam int         IDLE_LIMIT  = 4000;
  localparam int         HOLD_CYCLES = 600;
  localparam int         NUM_PHASES  = 8;
  localparam int         RAND_ITEMS  = 180;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] speed;
    logic [63:0]        freq;
    logic               fwd;
    logic signed [31:0] flow;
  } conv_req_t;

  typedef struct {
    logic [63:0]        freq;
    logic signed [31:0] rpm;
    logic               sat;
  } conv_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [pscv_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pscv_pkg::CfgDataW-1:0] cfg_data_i;

  pscv_in_if  req_if ();
  pscv_out_if res_if ();

  pump_speed_unit_converter_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_if.sink),
    .out_o     (res_if.source)
  );

  // Shadow copy of the converter registers
  logic [pscv_pkg::FullStepsW-1:0] sh_full_steps;
  logic [pscv_pkg::MicroW-1:0]     sh_micro;
  logic [pscv_pkg::GearW-1:0]      sh_gear_num;
  logic [pscv_pkg::GearW-1:0]      sh_gear_den;
  logic [pscv_pkg::DispW-1:0]      sh_disp;

  conv_req_t pending_reqs[$];
  conv_res_t expected_results[$];

  bit req_taken;
  bit res_taken;
  bit no_idle;
  bit hold_req;
  int req_gap;
  int res_stall;
  int hold_left;
  int mismatches;
  int idle_cycles;

  // Convert one request under the current shadow registers.
  function automatic conv_res_t convert(conv_req_t r);
    conv_res_t   res;
    logic [40:0] spr;
    logic [40:0] num;
    logic [32:0] mag;
    logic [73:0] q0;
    logic [69:0] q1;
    logic [31:0] m;
    longint      v;
    res = '{freq: '0, rpm: '0, sat: 1'b0};
    num = 41'(sh_full_steps) * 41'(sh_micro) * 41'(sh_gear_num);
    spr = (sh_gear_den == '0) ? '0 : num / 41'(sh_gear_den);
    case (r.mode)
      pscv_pkg::MODE_RPM_TO_FREQ: begin
        if (spr != '0) begin
          mag = r.speed[31] ? 33'($unsigned(~r.speed)) + 33'd1 : 33'($unsigned(r.speed));
          q0 = (74'(mag) * 74'(spr)) / 74'd60;
          if (q0[73:64] != '0) begin
            res.freq = '1;
            res.sat  = 1'b1;
          end else begin
            res.freq = q0[63:0];
          end
        end
      end
      pscv_pkg::MODE_FREQ_TO_RPM: begin
        if (spr != '0) begin
          q1 = (70'(r.freq) * 70'd60) / 70'(spr);
          if (q1 > 70'h7fffffff) begin
            m       = 32'h7fffffff;
            res.sat = 1'b1;
          end else begin
            m = q1[31:0];
          end
          res.rpm = r.fwd ? m : -m;
        end
      end
      pscv_pkg::MODE_FLOW_TO_RPM: begin
        if (sh_disp != '0) begin
          v = (longint'(r.flow) * 64'sd1000) / longint'({33'd0, sh_disp});
          if (v > 64'sd2147483647) begin
            v       = 64'sd2147483647;
            res.sat = 1'b1;
          end else if (v < -64'sd2147483648) begin
            v       = -64'sd2147483648;
            res.sat = 1'b1;
          end
          res.rpm = v[31:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: change inputs on the falling edge, hold until transfer.
  initial begin
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.speed_milli_rpm = '0;
    req_if.step_freq_millihertz = '0;
    req_if.direction_forward = 1'b0;
    req_if.flow_ul_per_min = '0;
    res_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
  end

  always @(negedge clk_i) begin
    conv_req_t cur;
    logic      nv;
    nv = req_if.valid;
    if (rst_ni) begin
      // drop the item just transferred and draw the gap before the next one
      if (req_if.valid && req_taken) begin
        nv        = 1'b0;
        req_taken = 1'b0;
        req_gap   = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          req_if.mode                 <= cur.mode;
          req_if.speed_milli_rpm      <= cur.speed;
          req_if.step_freq_millihertz <= cur.freq;
          req_if.direction_forward    <= cur.fwd;
          req_if.flow_ul_per_min      <= cur.flow;
          nv = 1'b1;
        end
      end
    end
    req_if.valid <= nv;
  end

  // Result receiver: a random stall after each transfer, plus one long hold-off.
  always @(negedge clk_i) begin
    logic nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (res_taken) begin
        res_taken = 1'b0;
        res_stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (res_stall > 0) begin
        res_stall--;
      end else begin
        nr = 1'b1;
      end
    end
    res_if.ready <= nr;
  end

  // Sample both channels at the rising edge: predict, compare, watch for hangs.
  always @(posedge clk_i) begin
    conv_req_t r;
    conv_res_t exp_res;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        r.mode  = req_if.mode;
        r.speed = req_if.speed_milli_rpm;
        r.freq  = req_if.step_freq_millihertz;
        r.fwd   = req_if.direction_forward;
        r.flow  = req_if.flow_ul_per_min;
        expected_results.push_back(convert(r));
        req_taken = 1'b1;
        moved     = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        res_taken = 1'b1;
        moved     = 1'b1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result freq=%h rpm=%0d sat=%b",
                     res_if.freq_out_millihertz, res_if.rpm_out_milli, res_if.saturated);
        end else begin
          exp_res = expected_results.pop_front();
          if (res_if.freq_out_millihertz !== exp_res.freq ||
              res_if.rpm_out_milli !== exp_res.rpm || res_if.saturated !== exp_res.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected freq=%h rpm=%0d sat=%b, got freq=%h rpm=%0d sat=%b",
                       exp_res.freq, exp_res.rpm, exp_res.sat, res_if.freq_out_millihertz,
                       res_if.rpm_out_milli, res_if.saturated);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic conv_req_t mk_req(logic [1:0] mode, logic signed [31:0] speed,
                                       logic [63:0] freq, logic fwd,
                                       logic signed [31:0] flow);
    conv_req_t r;
    r.mode  = mode;
    r.speed = speed;
    r.freq  = freq;
    r.fwd   = fwd;
    r.flow  = flow;
    return r;
  endfunction

  // Signed 32-bit value biased toward extremes and small magnitudes.
  function automatic logic signed [31:0] rand_s32();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff - $urandom_range(0, 3);
      1:       return 32'sh80000000 + $urandom_range(0, 3);
      2:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic conv_req_t rand_req();
    conv_req_t r;
    int        sel;
    sel = $urandom_range(0, 15);
    r.mode  = (sel == 15) ? MODE_NONE : 2'(sel % 3);
    r.speed = rand_s32();
    r.freq  = {$urandom, $urandom} >> $urandom_range(0, 63);
    if ($urandom_range(0, 9) == 0) r.freq = '1;
    r.fwd   = 1'($urandom_range(0, 1));
    r.flow  = rand_s32();
    return r;
  endfunction

  // Write all five registers, one per cycle, then release the write enable.
  task automatic write_regs(logic [15:0] fs, logic [8:0] ms, logic [15:0] gn,
                            logic [15:0] gd, logic [30:0] disp);
    logic [pscv_pkg::CfgIdxW-1:0]  idx  [5];
    logic [pscv_pkg::CfgDataW-1:0] data [5];
    idx  = '{pscv_pkg::REG_FULL_STEPS, pscv_pkg::REG_MICROSTEP, pscv_pkg::REG_GEAR_NUM,
             pscv_pkg::REG_GEAR_DEN, pscv_pkg::REG_DISPLACEMENT};
    data = '{31'(fs), 31'(ms), 31'(gn), 31'(gd), disp};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= data[i];
    end
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    sh_full_steps = fs;
    sh_micro      = ms;
    sh_gear_num   = gn;
    sh_gear_den   = gd;
    sh_disp       = disp;
  endtask

  task automatic load_directed();
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_RPM_TO_FREQ, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_RPM_TO_FREQ, 1, '1, 1'b1, -1));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_RPM_TO_FREQ, -1, 0, 1'b0, 1));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_RPM_TO_FREQ, 32'sh7fffffff, 0, 1'b0, 0));
    // most negative speed: magnitude one beyond the positive range
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_RPM_TO_FREQ, 32'sh80000000, '1, 1'b1, '1));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, '1, 0, 1'b1, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, '1, 0, 1'b0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, 0, 64'd1, 1'b1, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, 0, 64'd3200, 1'b0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, -1, 64'h1_0000_0000, 1'b1, -1));
    // frequency large enough to clamp the rpm in both directions
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, 0, '1, 1'b1, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, 0, '1, 1'b0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FREQ_TO_RPM, 0, 64'd0, 1'b0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FLOW_TO_RPM, 0, 0, 1'b0, 0));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FLOW_TO_RPM, 0, 0, 1'b0, 32'sh7fffffff));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FLOW_TO_RPM, 0, 0, 1'b0, 32'sh80000000));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FLOW_TO_RPM, 0, 0, 1'b0, -1));
    pending_reqs.push_back(mk_req(pscv_pkg::MODE_FLOW_TO_RPM, '1, '1, 1'b1, 1));
    pending_reqs.push_back(mk_req(MODE_NONE, '1, '1, 1'b1, '1));
    pending_reqs.push_back(mk_req(MODE_NONE, 0, 0, 1'b0, 0));
  endtask

  // Stimulus: one phase per register setting, idle in between.
  initial begin
    sh_full_steps = pscv_pkg::RST_FULL_STEPS;
    sh_micro      = pscv_pkg::RST_MICROSTEP;
    sh_gear_num   = pscv_pkg::RST_GEAR_NUM;
    sh_gear_den   = pscv_pkg::RST_GEAR_DEN;
    sh_disp       = pscv_pkg::RST_DISPLACEMENT;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;  // reset defaults
        1: write_regs(16'hffff, 9'd256, 16'hffff, 16'd1, 31'd1);
        2: write_regs(16'd200, 9'd16, 16'd3, 16'd0, 31'd0);
        // steps per rev truncates to zero; largest displacement
        3: write_regs(16'd1, 9'd1, 16'd1, 16'hffff, 31'h7fffffff);
        4: write_regs(16'd0, 9'd0, 16'd0, 16'd7, 31'd3);
        default: write_regs(16'($urandom), 9'($urandom_range(0, 256)), 16'($urandom),
                            16'($urandom_range(1, 65535)),
                            31'($urandom >> $urandom_range(0, 30)));
      endcase
      no_idle = (ph == 2);
      load_directed();
      for (int i = 0; i < RAND_ITEMS; i++) pending_reqs.push_back(rand_req());
      if (ph == 1) begin
        // hold the receiver off long enough to back up the whole pipeline
        repeat (20) @(posedge clk_i);
        hold_req = 1'b1;
      end
      while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
        @(posedge clk_i);
      repeat (PIPE_LAT + 10) @(posedge clk_i);
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
